[rtl/sjps_pkg.sv]
// sjps_pkg: widths, duty limits, phase and register codes, pipeline structs
// shared by every module of the servo jump phase sequencer; no dependencies
`default_nettype none

package sjps_pkg;

	localparam int NUM_LANES  = 4;
	localparam int NUM_PHASES = 4;
	localparam int REC_IDX_W  = $clog2(NUM_PHASES);

	localparam int TIME_W     = 16;
	localparam int BASE_W     = 16;
	localparam int HEIGHT_W   = 14;
	localparam int DUTY_W     = 14;
	localparam int OFS_W      = 15;
	localparam int EXT_W      = 17;
	localparam int TGT_W      = 18;
	localparam int DIFF_W     = 19;
	localparam int MASK_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [HEIGHT_W-1:0] HEIGHT_ZERO = 14'd10000;

	localparam logic signed [TGT_W-1:0]  DUTY_MIN     = 18'sd250;
	localparam logic signed [TGT_W-1:0]  DUTY_MAX     = 18'sd1250;
	localparam logic signed [TGT_W-1:0]  NEUTRAL_DUTY = 18'sd750;
	localparam logic signed [DIFF_W-1:0] TOLERANCE    = 19'sd5;
	localparam logic signed [DIFF_W-1:0] FAST_SLEW    = 19'sd10000;
	localparam logic signed [DIFF_W-1:0] SOFT_SLEW    = 19'sd20;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_TRIGGER = 1'b1;

	localparam logic [TIME_W-1:0] LAUNCH_END_RST   = 16'd100;
	localparam logic [TIME_W-1:0] FLIGHT_END_RST   = 16'd200;
	localparam logic [TIME_W-1:0] LANDING_END_RST  = 16'd220;
	localparam logic [TIME_W-1:0] RECOVERY_END_RST = 16'd280;
	localparam logic signed [OFS_W-1:0] LAUNCH_OFS_RST  = 15'sd2700;
	localparam logic signed [OFS_W-1:0] FLIGHT_OFS_RST  = -15'sd1500;
	localparam logic signed [OFS_W-1:0] LANDING_OFS_RST = 15'sd1700;
	localparam logic [MASK_W-1:0] DIR_MASK_RST = 4'd9;

	typedef enum logic [2:0] {
		PH_NONE     = 3'd0,
		PH_LAUNCH   = 3'd1,
		PH_FLIGHT   = 3'd2,
		PH_LANDING  = 3'd3,
		PH_RECOVERY = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAUNCH_END   = 3'd0,
		CFG_FLIGHT_END   = 3'd1,
		CFG_LANDING_END  = 3'd2,
		CFG_RECOVERY_END = 3'd3,
		CFG_LAUNCH_OFS   = 3'd4,
		CFG_FLIGHT_OFS   = 3'd5,
		CFG_LANDING_OFS  = 3'd6,
		CFG_DIR_MASK     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic adv1;
		logic adv2;
		logic adv3;
	} pipe_t;

	typedef struct packed {
		logic              drive;
		logic              slow_slew;
		logic              clear_rec;
		phase_t            phase;
		logic [TIME_W-1:0] t;
	} item_ctl_t;

endpackage

`default_nettype wire

[rtl/sjps_front.sv]
// sjps_front: configuration registers, jump state, elapsed counter and phase pick
// produces the per-item control word and the leg extension; uses sjps_pkg
`default_nettype none

module sjps_front (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  sjps_pkg::pipe_t                       pipe,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [sjps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [sjps_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                   op,
	input  wire  [sjps_pkg::HEIGHT_W-1:0]         height_code,
	output logic signed [sjps_pkg::EXT_W-1:0]     ext,
	output logic [sjps_pkg::MASK_W-1:0]           dir_mask,
	output sjps_pkg::item_ctl_t                   ctl_s1
);

	logic [sjps_pkg::TIME_W-1:0] launch_end_q, flight_end_q, landing_end_q, recovery_end_q;
	logic signed [sjps_pkg::OFS_W-1:0] launch_ofs_q, flight_ofs_q, landing_ofs_q;
	logic [sjps_pkg::MASK_W-1:0] dir_mask_q;
	logic active_q;
	logic [sjps_pkg::TIME_W-1:0] elapsed_q;

	sjps_pkg::phase_t sel_phase;
	logic signed [sjps_pkg::OFS_W-1:0] sel_ofs;
	logic sel_slow;
	logic [sjps_pkg::HEIGHT_W-1:0] h_eff;
	sjps_pkg::item_ctl_t ctl_next;

	assign cfg_ready = 1'b1;
	assign dir_mask  = dir_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_end_q   <= sjps_pkg::LAUNCH_END_RST;
			flight_end_q   <= sjps_pkg::FLIGHT_END_RST;
			landing_end_q  <= sjps_pkg::LANDING_END_RST;
			recovery_end_q <= sjps_pkg::RECOVERY_END_RST;
			launch_ofs_q   <= sjps_pkg::LAUNCH_OFS_RST;
			flight_ofs_q   <= sjps_pkg::FLIGHT_OFS_RST;
			landing_ofs_q  <= sjps_pkg::LANDING_OFS_RST;
			dir_mask_q     <= sjps_pkg::DIR_MASK_RST;
		end else if (cfg_valid) begin
			unique case (sjps_pkg::cfg_idx_t'(cfg_index))
				sjps_pkg::CFG_LAUNCH_END:   launch_end_q   <= cfg_data;
				sjps_pkg::CFG_FLIGHT_END:   flight_end_q   <= cfg_data;
				sjps_pkg::CFG_LANDING_END:  landing_end_q  <= cfg_data;
				sjps_pkg::CFG_RECOVERY_END: recovery_end_q <= cfg_data;
				sjps_pkg::CFG_LAUNCH_OFS:   launch_ofs_q   <= $signed(cfg_data[sjps_pkg::OFS_W-1:0]);
				sjps_pkg::CFG_FLIGHT_OFS:   flight_ofs_q   <= $signed(cfg_data[sjps_pkg::OFS_W-1:0]);
				sjps_pkg::CFG_LANDING_OFS:  landing_ofs_q  <= $signed(cfg_data[sjps_pkg::OFS_W-1:0]);
				sjps_pkg::CFG_DIR_MASK:     dir_mask_q     <= cfg_data[sjps_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// phase windows checked in order, so an empty window is skipped
	always_comb begin
		sel_phase = sjps_pkg::PH_NONE;
		sel_ofs   = '0;
		sel_slow  = 1'b0;
		if (elapsed_q <= launch_end_q) begin
			sel_phase = sjps_pkg::PH_LAUNCH;
			sel_ofs   = launch_ofs_q;
		end else if (elapsed_q <= flight_end_q) begin
			sel_phase = sjps_pkg::PH_FLIGHT;
			sel_ofs   = flight_ofs_q;
		end else if (elapsed_q <= landing_end_q) begin
			sel_phase = sjps_pkg::PH_LANDING;
			sel_ofs   = landing_ofs_q;
		end else if (elapsed_q <= recovery_end_q) begin
			sel_phase = sjps_pkg::PH_RECOVERY;
			sel_slow  = 1'b1;
		end
	end

	always_comb begin
		h_eff = (height_code == sjps_pkg::HEIGHT_ZERO) ? '0 : height_code;
		ext   = $signed({{(sjps_pkg::EXT_W-sjps_pkg::HEIGHT_W){1'b0}}, h_eff})
			+ $signed({{(sjps_pkg::EXT_W-sjps_pkg::OFS_W){sel_ofs[sjps_pkg::OFS_W-1]}}, sel_ofs});
	end

	always_comb begin
		ctl_next.drive     = 1'b0;
		ctl_next.slow_slew = 1'b0;
		ctl_next.clear_rec = 1'b0;
		ctl_next.phase     = sjps_pkg::PH_NONE;
		ctl_next.t         = elapsed_q;
		if (op == sjps_pkg::OP_TRIGGER) begin
			ctl_next.phase     = sjps_pkg::PH_LAUNCH;
			ctl_next.clear_rec = !active_q;
		end else if (active_q) begin
			ctl_next.phase     = sel_phase;
			ctl_next.drive     = (sel_phase != sjps_pkg::PH_NONE);
			ctl_next.slow_slew = sel_slow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			elapsed_q <= '0;
		end else if (pipe.adv1) begin
			if (op == sjps_pkg::OP_TRIGGER) begin
				if (!active_q) begin
					active_q  <= 1'b1;
					elapsed_q <= '0;
				end
			end else if (active_q) begin
				if (elapsed_q != sjps_pkg::TIME_MAX) begin
					elapsed_q <= elapsed_q + 1'b1;
				end
				if (sel_phase == sjps_pkg::PH_NONE) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.adv1) begin
			ctl_s1 <= ctl_next;
		end
	end

endmodule

`default_nettype wire

[rtl/sjps_lane.sv]
// sjps_lane: one servo channel: target, slew accumulator, duty clamp, reach check
// instantiated once per channel by the top level; uses sjps_pkg
`default_nettype none

module sjps_lane (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  sjps_pkg::pipe_t                       pipe,
	input  sjps_pkg::item_ctl_t                   ctl_s1,
	input  wire  [sjps_pkg::BASE_W-1:0]           base,
	input  wire                                   dir,
	input  wire  signed [sjps_pkg::EXT_W-1:0]     ext,
	output logic [sjps_pkg::DUTY_W-1:0]           duty,
	output logic                                  ok
);

	logic signed [sjps_pkg::TGT_W-1:0]  target_c, target_s1, target_s2;
	logic signed [sjps_pkg::TGT_W-1:0]  slewed_q, slewed_next, duty_full;
	logic signed [sjps_pkg::TGT_W-1:0]  base_x, ext_x;
	logic signed [sjps_pkg::DIFF_W-1:0] diff, lim, step, sum, err;

	always_comb begin
		base_x   = $signed({{(sjps_pkg::TGT_W-sjps_pkg::BASE_W){1'b0}}, base});
		ext_x    = $signed({{(sjps_pkg::TGT_W-sjps_pkg::EXT_W){ext[sjps_pkg::EXT_W-1]}}, ext});
		target_c = dir ? (base_x + ext_x) : (base_x - ext_x);
	end

	always_comb begin
		diff = $signed({target_s1[sjps_pkg::TGT_W-1], target_s1})
			- $signed({slewed_q[sjps_pkg::TGT_W-1], slewed_q});
		lim  = ctl_s1.slow_slew ? sjps_pkg::SOFT_SLEW : sjps_pkg::FAST_SLEW;
		if (diff > lim) begin
			step = lim;
		end else if (diff < -lim) begin
			step = -lim;
		end else begin
			step = diff;
		end
		sum         = $signed({slewed_q[sjps_pkg::TGT_W-1], slewed_q}) + step;
		slewed_next = sum[sjps_pkg::TGT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slewed_q <= sjps_pkg::NEUTRAL_DUTY;
		end else if (pipe.adv2 && ctl_s1.drive) begin
			slewed_q <= slewed_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.adv1) begin
			target_s1 <= target_c;
		end
		if (pipe.adv2) begin
			target_s2 <= target_s1;
		end
	end

	always_comb begin
		if (slewed_q < sjps_pkg::DUTY_MIN) begin
			duty_full = sjps_pkg::DUTY_MIN;
		end else if (slewed_q > sjps_pkg::DUTY_MAX) begin
			duty_full = sjps_pkg::DUTY_MAX;
		end else begin
			duty_full = slewed_q;
		end
		duty = duty_full[sjps_pkg::DUTY_W-1:0];
		err  = $signed({target_s2[sjps_pkg::TGT_W-1], target_s2})
			- $signed({duty_full[sjps_pkg::TGT_W-1], duty_full});
		ok   = (err >= -sjps_pkg::TOLERANCE) && (err <= sjps_pkg::TOLERANCE);
	end

endmodule

`default_nettype wire

[rtl/sjps_merge.sv]
// sjps_merge: combines the lane results, keeps the per-phase reach records
// and holds the output register; uses sjps_pkg
`default_nettype none

module sjps_merge (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  sjps_pkg::pipe_t                       pipe,
	input  sjps_pkg::item_ctl_t                   ctl_s1,
	input  wire  [sjps_pkg::DUTY_W-1:0]           lane_duty [sjps_pkg::NUM_LANES],
	input  wire  [sjps_pkg::NUM_LANES-1:0]        lane_ok,
	output logic [2:0]                            phase_s3,
	output logic                                  drive_s3,
	output logic [sjps_pkg::DUTY_W-1:0]           duty_s3 [sjps_pkg::NUM_LANES],
	output logic                                  reached_s3,
	output logic [sjps_pkg::TIME_W-1:0]           rec_q [sjps_pkg::NUM_PHASES]
);

	sjps_pkg::item_ctl_t ctl_s2;
	logic reached;
	logic [2:0] phase_m1;
	logic [sjps_pkg::REC_IDX_W-1:0] rec_idx;

	always_comb begin
		reached  = ctl_s2.drive && (&lane_ok);
		phase_m1 = ctl_s2.phase - 3'd1;
		rec_idx  = phase_m1[sjps_pkg::REC_IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (pipe.adv2) begin
			ctl_s2 <= ctl_s1;
		end
		if (pipe.adv3) begin
			phase_s3   <= ctl_s2.phase;
			drive_s3   <= ctl_s2.drive;
			reached_s3 <= reached;
			for (int k = 0; k < sjps_pkg::NUM_LANES; k++) begin
				duty_s3[k] <= ctl_s2.drive ? lane_duty[k] : '0;
			end
		end
	end

	// a record keeps the first reach time of its phase; zero reads as unset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < sjps_pkg::NUM_PHASES; k++) begin
				rec_q[k] <= '0;
			end
		end else if (pipe.adv3) begin
			if (ctl_s2.clear_rec) begin
				for (int k = 0; k < sjps_pkg::NUM_PHASES; k++) begin
					rec_q[k] <= '0;
				end
			end else if (reached && (rec_q[rec_idx] == '0)) begin
				rec_q[rec_idx] <= ctl_s2.t;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/servo_jump_phase_sequencer.sv]
// servo_jump_phase_sequencer: jump phase sequencer driving four servo duties
// registered in stages s1, s2, s3 from input to result; one item per cycle
// unless out_ready stalls, set by the lane slew accumulators and elapsed counter
// reset: default end times, offsets and mask, no jump, slewed duties neutral,
// reach records zero; depends on sjps_pkg, sjps_front, sjps_lane, sjps_merge
`default_nettype none

module servo_jump_phase_sequencer (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   op,
	input  wire  [sjps_pkg::HEIGHT_W-1:0]         height_code,
	input  wire  [sjps_pkg::BASE_W-1:0]           base_front_left,
	input  wire  [sjps_pkg::BASE_W-1:0]           base_front_right,
	input  wire  [sjps_pkg::BASE_W-1:0]           base_rear_right,
	input  wire  [sjps_pkg::BASE_W-1:0]           base_rear_left,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [2:0]                            phase,
	output logic                                  drive_valid,
	output logic [sjps_pkg::DUTY_W-1:0]           duty_front_left,
	output logic [sjps_pkg::DUTY_W-1:0]           duty_front_right,
	output logic [sjps_pkg::DUTY_W-1:0]           duty_rear_right,
	output logic [sjps_pkg::DUTY_W-1:0]           duty_rear_left,
	output logic                                  lanes_settled,
	output logic [sjps_pkg::TIME_W-1:0]           launch_reach_ms,
	output logic [sjps_pkg::TIME_W-1:0]           flight_reach_ms,
	output logic [sjps_pkg::TIME_W-1:0]           landing_reach_ms,
	output logic [sjps_pkg::TIME_W-1:0]           recovery_reach_ms,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [sjps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [sjps_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	sjps_pkg::pipe_t pipe;
	sjps_pkg::item_ctl_t ctl_s1;
	logic signed [sjps_pkg::EXT_W-1:0] ext;
	logic [sjps_pkg::MASK_W-1:0] dir_mask;
	logic [sjps_pkg::BASE_W-1:0] base_a [sjps_pkg::NUM_LANES];
	logic [sjps_pkg::DUTY_W-1:0] lane_duty [sjps_pkg::NUM_LANES];
	logic [sjps_pkg::NUM_LANES-1:0] lane_ok;
	logic [sjps_pkg::DUTY_W-1:0] duty_s3 [sjps_pkg::NUM_LANES];
	logic [sjps_pkg::TIME_W-1:0] rec_q [sjps_pkg::NUM_PHASES];

	always_comb begin
		rdy3      = !v_s3 || out_ready;
		rdy2      = !v_s2 || rdy3;
		rdy1      = !v_s1 || rdy2;
		in_ready  = rdy1;
		pipe.adv1 = in_valid && rdy1;
		pipe.adv2 = v_s1 && rdy2;
		pipe.adv3 = v_s2 && rdy3;
		out_valid = v_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign base_a[0] = base_front_left;
	assign base_a[1] = base_front_right;
	assign base_a[2] = base_rear_right;
	assign base_a[3] = base_rear_left;

	sjps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pipe        (pipe),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.height_code (height_code),
		.ext         (ext),
		.dir_mask    (dir_mask),
		.ctl_s1      (ctl_s1)
	);

	for (genvar k = 0; k < sjps_pkg::NUM_LANES; k++) begin : g_lane
		sjps_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.pipe   (pipe),
			.ctl_s1 (ctl_s1),
			.base   (base_a[k]),
			.dir    (dir_mask[k]),
			.ext    (ext),
			.duty   (lane_duty[k]),
			.ok     (lane_ok[k])
		);
	end

	sjps_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe       (pipe),
		.ctl_s1     (ctl_s1),
		.lane_duty  (lane_duty),
		.lane_ok    (lane_ok),
		.phase_s3   (phase),
		.drive_s3   (drive_valid),
		.duty_s3    (duty_s3),
		.reached_s3 (lanes_settled),
		.rec_q      (rec_q)
	);

	assign duty_front_left   = duty_s3[0];
	assign duty_front_right  = duty_s3[1];
	assign duty_rear_right   = duty_s3[2];
	assign duty_rear_left    = duty_s3[3];
	assign launch_reach_ms   = rec_q[0];
	assign flight_reach_ms   = rec_q[1];
	assign landing_reach_ms  = rec_q[2];
	assign recovery_reach_ms = rec_q[3];

endmodule

`default_nettype wire

[bench/tb_top.sv]
// tb_top: self-checking bench for servo_jump_phase_sequencer with an item-level predictor
// of jump phases, slewed duties and reach records; depends on sjps_pkg and the rtl top
`timescale 1ns / 100ps

module tb_top;
	import sjps_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int DUTY_LO = DUTY_MIN;
	localparam int DUTY_HI = DUTY_MAX;
	localparam int TOL = TOLERANCE;
	localparam int SLEW_FAST = FAST_SLEW;
	localparam int SLEW_SOFT = SOFT_SLEW;

	typedef struct packed {
		phase_t              phase;
		logic                drive;
		logic [3:0][13:0]    duty;
		logic                hit;
		logic [3:0][15:0]    reach;
	} servo_frame_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, op;
	logic [HEIGHT_W-1:0] height_code;
	logic [BASE_W-1:0] base_front_left, base_front_right, base_rear_right, base_rear_left;
	logic out_valid, out_ready;
	logic [2:0] phase;
	logic drive_valid, lanes_settled;
	logic [DUTY_W-1:0] duty_front_left, duty_front_right, duty_rear_right, duty_rear_left;
	logic [TIME_W-1:0] launch_reach_ms, flight_reach_ms, landing_reach_ms, recovery_reach_ms;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state and register copy
	int end_ms[4];
	int leg_ofs[3];
	logic [3:0] dir_mask;
	logic jump_on;
	int elapsed;
	int slewed[4];
	logic [3:0][15:0] reach_rec;

	servo_frame_t frame_q[$];
	int lane_goal[4];
	int fail_count = 0;
	int items_sent = 0;
	int stall_cycles = 0;
	bit gaps_on = 1'b1;

	servo_jump_phase_sequencer u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic phase_t phase_for(int t, output int ofs, output int slew);
		ofs = 0;
		slew = SLEW_FAST;
		if (t <= end_ms[0]) begin
			ofs = leg_ofs[0];
			return PH_LAUNCH;
		end
		if (t <= end_ms[1]) begin
			ofs = leg_ofs[1];
			return PH_FLIGHT;
		end
		if (t <= end_ms[2]) begin
			ofs = leg_ofs[2];
			return PH_LANDING;
		end
		if (t <= end_ms[3]) begin
			slew = SLEW_SOFT;
			return PH_RECOVERY;
		end
		return PH_NONE;
	endfunction

	function automatic servo_frame_t advance_jump(logic op_i, logic [13:0] h_i,
			logic [3:0][15:0] b_i);
		servo_frame_t f;
		phase_t ph;
		int t, hgt, ofs, slew, tgt, step, duty, err, k;
		logic hit;
		f = '0;
		if (op_i == OP_TRIGGER) begin
			if (!jump_on) begin
				jump_on = 1'b1;
				elapsed = 0;
				reach_rec = '0;
			end
			f.phase = PH_LAUNCH;
			f.reach = reach_rec;
			return f;
		end
		ph = PH_NONE;
		t = 0;
		if (jump_on) begin
			t = elapsed;
			if (elapsed < 65535) elapsed++;
			ph = phase_for(t, ofs, slew);
			if (ph == PH_NONE) jump_on = 1'b0;
		end
		if (ph != PH_NONE) begin
			hgt = (h_i == HEIGHT_ZERO) ? 0 : int'(h_i);
			hit = 1'b1;
			for (k = 0; k < NUM_LANES; k++) begin
				tgt = dir_mask[k] ? int'(b_i[k]) + hgt + ofs : int'(b_i[k]) - hgt - ofs;
				step = tgt - slewed[k];
				if (step < -slew) step = -slew;
				else if (step > slew) step = slew;
				slewed[k] += step;
				duty = slewed[k];
				if (duty < DUTY_LO) duty = DUTY_LO;
				else if (duty > DUTY_HI) duty = DUTY_HI;
				f.duty[k] = duty[13:0];
				err = tgt - duty;
				if (err < 0) err = -err;
				if (err > TOL) hit = 1'b0;
			end
			if (hit && reach_rec[int'(ph) - 1] == 16'd0) reach_rec[int'(ph) - 1] = t[15:0];
			f.drive = 1'b1;
			f.hit = hit;
		end
		f.phase = ph;
		f.reach = reach_rec;
		return f;
	endfunction

	task automatic report_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 40)
				$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
		end
	endtask

	task automatic send_item(logic op_i, logic [13:0] h_i, logic [3:0][15:0] b_i);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			op = 1'($urandom);
			height_code = 14'($urandom);
			base_front_left = 16'($urandom);
			base_rear_left = 16'($urandom);
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid = 1'b1;
		op = op_i;
		height_code = h_i;
		base_front_left = b_i[0];
		base_front_right = b_i[1];
		base_rear_right = b_i[2];
		base_rear_left = b_i[3];
		do @(posedge clk); while (!in_ready);
		frame_q.push_back(advance_jump(op_i, h_i, b_i));
		items_sent++;
	endtask

	// bases chosen so that each lane target lands near its goal in the coming phase
	task automatic send_tracking_tick(logic [13:0] h_raw);
		logic [3:0][15:0] b;
		int ofs, slew, ext, v, k;
		void'(phase_for(elapsed, ofs, slew));
		ext = ((h_raw == HEIGHT_ZERO) ? 0 : int'(h_raw)) + ofs;
		for (k = 0; k < NUM_LANES; k++) begin
			v = dir_mask[k] ? lane_goal[k] - ext : lane_goal[k] + ext;
			if ($urandom_range(0, 5) == 0) v = v + int'($urandom_range(0, 12)) - 6;
			if (v < 0) v = 0;
			else if (v > 65535) v = 65535;
			b[k] = 16'(v);
		end
		send_item(OP_TICK, h_raw, b);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LAUNCH_END:   end_ms[0] = int'(val);
			CFG_FLIGHT_END:   end_ms[1] = int'(val);
			CFG_LANDING_END:  end_ms[2] = int'(val);
			CFG_RECOVERY_END: end_ms[3] = int'(val);
			CFG_LAUNCH_OFS:   leg_ofs[0] = int'($signed(val[14:0]));
			CFG_FLIGHT_OFS:   leg_ofs[1] = int'($signed(val[14:0]));
			CFG_LANDING_OFS:  leg_ofs[2] = int'($signed(val[14:0]));
			CFG_DIR_MASK:     dir_mask = val[3:0];
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_profile(int e0, int e1, int e2, int e3, int o0, int o1, int o2,
			logic [3:0] m);
		wait_results_drained();
		write_reg(CFG_LAUNCH_END, 16'(e0));
		write_reg(CFG_FLIGHT_END, 16'(e1));
		write_reg(CFG_LANDING_END, 16'(e2));
		write_reg(CFG_RECOVERY_END, 16'(e3));
		write_reg(CFG_LAUNCH_OFS, {1'($urandom), 15'(o0)});
		write_reg(CFG_FLIGHT_OFS, {1'($urandom), 15'(o1)});
		write_reg(CFG_LANDING_OFS, {1'($urandom), 15'(o2)});
		write_reg(CFG_DIR_MASK, {12'($urandom), m});
	endtask

	task automatic test_reset_profile();
		send_item(OP_TICK, 14'h3FFF, {4{16'hFFFF}});
		send_item(OP_TICK, 14'd0, {4{16'h0000}});
		send_item(OP_TRIGGER, HEIGHT_ZERO, {16'd1, 16'd2, 16'd3, 16'd4});
		send_item(OP_TICK, HEIGHT_ZERO, {4{16'd750}});
		send_item(OP_TICK, 14'd0, {16'd0, 16'd65535, 16'd0, 16'd65535});
		send_item(OP_TRIGGER, 14'd5, {4{16'd100}});
		send_item(OP_TICK, 14'h3FFF, {4{16'hFFFF}});
		send_item(OP_TICK, 14'd8192, {16'd2000, 16'd3500, 16'd3500, 16'd2000});
	endtask

	task automatic test_short_jump();
		load_profile(1, 3, 4, 6, 0, 16383, -16384, 4'hF);
		send_item(OP_TRIGGER, 14'd0, {4{16'd0}});
		// the earlier jump is still active, so this trigger does not restart it
		send_item(OP_TICK, 14'd0, {4{16'd800}});
		send_item(OP_TICK, 14'd0, {4{16'd800}});
		send_item(OP_TICK, HEIGHT_ZERO, {4{16'hFFFF}});
		send_item(OP_TICK, 14'd0, {4{16'd0}});
		send_item(OP_TICK, 14'h3FFF, {4{16'd1000}});
		send_item(OP_TICK, 14'd0, {4{16'd1000}});
		send_item(OP_TICK, 14'd0, {4{16'd1000}});
		send_item(OP_TICK, 14'd0, {4{16'd1000}});
		send_item(OP_TICK, 14'd7, {4{16'd900}});
		send_item(OP_TRIGGER, 14'd0, {4{16'd900}});
	endtask

	task automatic test_unordered_ends();
		load_profile(1, 0, 3, 2, -10000, 10000, -1, 4'b0110);
		send_item(OP_TICK, 14'd0, {4{16'd900}});
		repeat (6) send_item(OP_TICK, 14'($urandom_range(0, 300)),
			{16'($urandom_range(0, 12000)), 16'($urandom_range(0, 12000)),
			 16'($urandom_range(0, 12000)), 16'($urandom_range(0, 12000))});
	endtask

	task automatic test_random_jumps();
		int e[4];
		int o[3];
		int i, r;
		logic [13:0] h;
		while (items_sent < 1250) begin
			if (items_sent > 1150) gaps_on = 1'b0;
			if ($urandom_range(0, 3) != 0) begin
				e[0] = $urandom_range(0, 8);
				for (i = 1; i < 4; i++) e[i] = e[i-1] + $urandom_range(0, 6);
			end else begin
				for (i = 0; i < 4; i++) e[i] = $urandom_range(0, 24);
			end
			for (i = 0; i < 3; i++) begin
				case ($urandom_range(0, 7))
					0: o[i] = -16384;
					1: o[i] = 16383;
					2: o[i] = -10000;
					3: o[i] = 10000;
					default: o[i] = int'($urandom_range(0, 20000)) - 10000;
				endcase
			end
			load_profile(e[0], e[1], e[2], e[3], o[0], o[1], o[2], 4'($urandom));
			repeat ($urandom_range(2, 5)) begin
				repeat ($urandom_range(0, 2))
					send_item(OP_TICK, 14'($urandom), {$urandom, $urandom});
				case ($urandom_range(0, 3))
					0: h = HEIGHT_ZERO;
					1: h = 14'($urandom);
					default: h = 14'($urandom_range(0, 600));
				endcase
				for (i = 0; i < 4; i++) begin
					case ($urandom_range(0, 3))
						0: lane_goal[i] = $urandom_range(240, 260);
						1: lane_goal[i] = $urandom_range(1240, 1260);
						default: lane_goal[i] = $urandom_range(150, 1350);
					endcase
				end
				send_item(OP_TRIGGER, 14'($urandom), {$urandom, $urandom});
				while (jump_on) begin
					r = $urandom_range(0, 59);
					if (r == 0) wait_results_drained();
					if (r < 3) send_item(OP_TRIGGER, 14'($urandom), {$urandom, $urandom});
					else if (r < 9) send_item(OP_TICK, 14'($urandom), {$urandom, $urandom});
					else begin
						if (r < 12) lane_goal[$urandom_range(0, 3)] = $urandom_range(150, 1350);
						send_tracking_tick(h);
					end
				end
			end
		end
	endtask

	task automatic test_long_recovery();
		int i;
		gaps_on = 1'b0;
		load_profile(0, 2, 5, 65535, 300, -300, 0, 4'b0101);
		for (i = 0; i < 4; i++) lane_goal[i] = $urandom_range(300, 1200);
		send_item(OP_TRIGGER, 14'd100, {4{16'd0}});
		repeat (40) send_tracking_tick(14'd100);
		send_item(OP_TRIGGER, 14'd0, {4{16'd0}});
		wait_results_drained();
		write_reg(CFG_RECOVERY_END, 16'd10);
		send_tracking_tick(14'd100);
		send_item(OP_TICK, 14'd100, {4{16'd500}});
	endtask

	// output side: ready stalls in bursts
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		servo_frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_q.size() == 0) report_field("result with none pending", 32'd1, 32'd0);
			else begin
				want = frame_q.pop_front();
				report_field("phase", 32'(phase), 32'(want.phase));
				report_field("drive_valid", 32'(drive_valid), 32'(want.drive));
				report_field("duty_front_left", 32'(duty_front_left), 32'(want.duty[0]));
				report_field("duty_front_right", 32'(duty_front_right), 32'(want.duty[1]));
				report_field("duty_rear_right", 32'(duty_rear_right), 32'(want.duty[2]));
				report_field("duty_rear_left", 32'(duty_rear_left), 32'(want.duty[3]));
				report_field("lanes_settled", 32'(lanes_settled), 32'(want.hit));
				report_field("launch_reach_ms", 32'(launch_reach_ms), 32'(want.reach[0]));
				report_field("flight_reach_ms", 32'(flight_reach_ms), 32'(want.reach[1]));
				report_field("landing_reach_ms", 32'(landing_reach_ms), 32'(want.reach[2]));
				report_field("recovery_reach_ms", 32'(recovery_reach_ms),
					32'(want.reach[3]));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		end_ms[0] = LAUNCH_END_RST;
		end_ms[1] = FLIGHT_END_RST;
		end_ms[2] = LANDING_END_RST;
		end_ms[3] = RECOVERY_END_RST;
		leg_ofs[0] = LAUNCH_OFS_RST;
		leg_ofs[1] = FLIGHT_OFS_RST;
		leg_ofs[2] = LANDING_OFS_RST;
		dir_mask = DIR_MASK_RST;
		jump_on = 1'b0;
		elapsed = 0;
		reach_rec = '0;
		for (int k = 0; k < NUM_LANES; k++) slewed[k] = NEUTRAL_DUTY;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_TICK;
		height_code = '0;
		base_front_left = '0;
		base_front_right = '0;
		base_rear_right = '0;
		base_rear_left = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LAUNCH_END;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_profile();
		test_short_jump();
		test_unordered_ends();
		test_random_jumps();
		test_long_recovery();

		wait_results_drained();
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
